FILE: rtl/tpo_pkg.sv
package tpo_pkg;

   // registered stages from input to result: diff, product, sum, flag, output
   localparam int PIPE_DEPTH = 5;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic load_diff;
      logic load_prod;
      logic load_sum;
      logic load_flag;
      logic load_out;
   } tpo_adv_type;

endpackage

FILE: rtl/tpo_if.sv
interface tpo_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x0;
   logic signed [COORD_WIDTH-1:0] a_y0;
   logic signed [COORD_WIDTH-1:0] a_x1;
   logic signed [COORD_WIDTH-1:0] a_y1;
   logic signed [COORD_WIDTH-1:0] a_x2;
   logic signed [COORD_WIDTH-1:0] a_y2;
   logic signed [COORD_WIDTH-1:0] b_x0;
   logic signed [COORD_WIDTH-1:0] b_y0;
   logic signed [COORD_WIDTH-1:0] b_x1;
   logic signed [COORD_WIDTH-1:0] b_y1;
   logic signed [COORD_WIDTH-1:0] b_x2;
   logic signed [COORD_WIDTH-1:0] b_y2;

   modport source (
      output valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
             b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
      input  ready
   );
   modport sink (
      input  valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
             b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
      output ready
   );
endinterface

interface tpo_rsp_if;
   logic valid;
   logic ready;
   logic overlap;

   modport source (output valid, overlap, input ready);
   modport sink (input valid, overlap, output ready);
endinterface

FILE: rtl/tpo_pipe_ctl.sv
module tpo_pipe_ctl
   import tpo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output tpo_adv_type adv
);

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic [PIPE_DEPTH-1:0] can_load;

   // a stage may load when it is empty or its content moves on this cycle
   always_comb begin
      can_load[PIPE_DEPTH-1] = !vld_ff[PIPE_DEPTH-1] || out_ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         can_load[k] = !vld_ff[k] || can_load[k+1];
      end
      vld_in[0] = can_load[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         vld_in[k] = can_load[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready      = can_load[0];
   assign out_valid     = vld_ff[PIPE_DEPTH-1];
   assign adv.load_diff = can_load[0];
   assign adv.load_prod = can_load[1];
   assign adv.load_sum  = can_load[2];
   assign adv.load_flag = can_load[3];
   assign adv.load_out  = can_load[4];

endmodule

FILE: rtl/tpo_sep_unit.sv
module tpo_sep_unit
   import tpo_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  tpo_adv_type                   adv,
   input  logic signed [COORD_WIDTH-1:0] p [6],
   input  logic signed [COORD_WIDTH-1:0] q [6],
   output logic                          sep
);

   localparam int DW = COORD_WIDTH + 1; // differences
   localparam int PW = 2 * DW;          // products
   localparam int SW = PW + 1;          // s, t, d
   localparam int EW = SW + 2;          // s + t - d

   // stage 1: edge and vertex differences relative to q2
   logic signed [DW-1:0] dx21_ff, dy12_ff, dy20_ff, dx02_ff, dyq_ff;
   logic signed [DW-1:0] dx21_in, dy12_in, dy20_in, dx02_in, dyq_in;
   logic signed [DW-1:0] dxp_ff [3];
   logic signed [DW-1:0] dyp_ff [3];
   logic signed [DW-1:0] dxp_in [3];
   logic signed [DW-1:0] dyp_in [3];

   // stage 2: products
   logic signed [PW-1:0] dpa_ff, dpb_ff, dpa_in, dpb_in;
   logic signed [PW-1:0] spa_ff [3];
   logic signed [PW-1:0] spb_ff [3];
   logic signed [PW-1:0] tpa_ff [3];
   logic signed [PW-1:0] tpb_ff [3];
   logic signed [PW-1:0] spa_in [3];
   logic signed [PW-1:0] spb_in [3];
   logic signed [PW-1:0] tpa_in [3];
   logic signed [PW-1:0] tpb_in [3];

   // stage 3: area term and per-vertex s, t
   logic signed [SW-1:0] d_ff, d_in;
   logic signed [SW-1:0] s_ff [3];
   logic signed [SW-1:0] t_ff [3];
   logic signed [SW-1:0] s_in [3];
   logic signed [SW-1:0] t_in [3];

   // stage 4: separation flag
   logic sep_ff, sep_in;
   logic signed [EW-1:0] e_sum [3];
   logic dneg, s_all, t_all, st_all;

   always_comb begin
      dx21_in = DW'(q[4]) - DW'(q[2]);
      dy12_in = DW'(q[3]) - DW'(q[5]);
      dy20_in = DW'(q[5]) - DW'(q[1]);
      dx02_in = DW'(q[0]) - DW'(q[4]);
      dyq_in  = DW'(q[1]) - DW'(q[5]);
      for (int i = 0; i < 3; i++) begin
         dxp_in[i] = DW'(p[2*i])   - DW'(q[4]);
         dyp_in[i] = DW'(p[2*i+1]) - DW'(q[5]);
      end
   end

   always_comb begin
      dpa_in = dy12_ff * dx02_ff;
      dpb_in = dx21_ff * dyq_ff;
      for (int i = 0; i < 3; i++) begin
         spa_in[i] = dy12_ff * dxp_ff[i];
         spb_in[i] = dx21_ff * dyp_ff[i];
         tpa_in[i] = dy20_ff * dxp_ff[i];
         tpb_in[i] = dx02_ff * dyp_ff[i];
      end
   end

   always_comb begin
      d_in = SW'(dpa_ff) + SW'(dpb_ff);
      for (int i = 0; i < 3; i++) begin
         s_in[i] = SW'(spa_ff[i]) + SW'(spb_ff[i]);
         t_in[i] = SW'(tpa_ff[i]) + SW'(tpb_ff[i]);
      end
   end

   // sense of each test follows the sign of d; touching counts as beyond
   always_comb begin
      dneg   = d_ff[SW-1];
      s_all  = 1'b1;
      t_all  = 1'b1;
      st_all = 1'b1;
      for (int i = 0; i < 3; i++) begin
         e_sum[i] = EW'(s_ff[i]) + EW'(t_ff[i]) - EW'(d_ff);
         if (dneg) begin
            if (s_ff[i][SW-1]) s_all = 1'b0;
            if (t_ff[i][SW-1]) t_all = 1'b0;
            if (!e_sum[i][EW-1] && (e_sum[i] != '0)) st_all = 1'b0;
         end else begin
            if (!s_ff[i][SW-1] && (s_ff[i] != '0)) s_all = 1'b0;
            if (!t_ff[i][SW-1] && (t_ff[i] != '0)) t_all = 1'b0;
            if (e_sum[i][EW-1]) st_all = 1'b0;
         end
      end
      sep_in = s_all || t_all || st_all;
   end

   always_ff @(posedge clock) begin
      if (adv.load_diff) begin
         dx21_ff <= dx21_in;
         dy12_ff <= dy12_in;
         dy20_ff <= dy20_in;
         dx02_ff <= dx02_in;
         dyq_ff  <= dyq_in;
         dxp_ff  <= dxp_in;
         dyp_ff  <= dyp_in;
      end
      if (adv.load_prod) begin
         dpa_ff <= dpa_in;
         dpb_ff <= dpb_in;
         spa_ff <= spa_in;
         spb_ff <= spb_in;
         tpa_ff <= tpa_in;
         tpb_ff <= tpb_in;
      end
      if (adv.load_sum) begin
         d_ff <= d_in;
         s_ff <= s_in;
         t_ff <= t_in;
      end
      if (adv.load_flag) begin
         sep_ff <= sep_in;
      end
   end

   assign sep = sep_ff;

endmodule

FILE: rtl/triangle_pair_overlap_test.sv
// Triangle pair overlap test, 2D separating-edge form.
// req_chan (valid/ready sink): one transaction carries triangle A and triangle B,
//   six signed COORD_WIDTH-bit coordinates each (x0, y0, x1, y1, x2, y2).
// rsp_chan (valid/ready source): one transaction per request, in order, with
//   overlap = 1 when the triangles intersect; touching only at an edge or a
//   vertex reports 0.
// Both directions run side by side: A tested against B's edges and B against
//   A's. Each direction is a four-stage datapath (differences, products, sums,
//   separation flag), followed by a shared output register.
// Path: a transaction moves through the difference, product, sum, flag and
//   output registers in turn when the output is not stalled.
// Throughput: one transaction per cycle unless rsp_chan stalls; the multiplier
//   stage (14 exact (COORD_WIDTH+1)-bit products per direction) sets the clock.
// Stall: each stage loads when it is empty or its content moves on, so
//   bubbles close up and req_chan.ready stays high until all five stages hold
//   work while rsp_chan.ready is low. Nothing is dropped or repeated.
// Reset (synchronous, active high) clears the stage valid bits only; no
//   configuration, no state carried between transactions.
module triangle_pair_overlap_test
   import tpo_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   tpo_req_if.sink   req_chan,
   tpo_rsp_if.source rsp_chan
);

   tpo_adv_type adv;

   logic signed [COORD_WIDTH-1:0] a_pt [6];
   logic signed [COORD_WIDTH-1:0] b_pt [6];

   logic sep_ab;     // A's vertices all beyond one of B's edges
   logic sep_ba;     // B's vertices all beyond one of A's edges
   logic overlap_ff;
   logic overlap_in;

   assign a_pt[0] = req_chan.a_x0;
   assign a_pt[1] = req_chan.a_y0;
   assign a_pt[2] = req_chan.a_x1;
   assign a_pt[3] = req_chan.a_y1;
   assign a_pt[4] = req_chan.a_x2;
   assign a_pt[5] = req_chan.a_y2;
   assign b_pt[0] = req_chan.b_x0;
   assign b_pt[1] = req_chan.b_y0;
   assign b_pt[2] = req_chan.b_x1;
   assign b_pt[3] = req_chan.b_y1;
   assign b_pt[4] = req_chan.b_x2;
   assign b_pt[5] = req_chan.b_y2;

   // stage valid bits and per-stage load strobes
   tpo_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .adv       (adv)
   );

   // B is the reference, A's vertices are tested
   tpo_sep_unit #(.COORD_WIDTH(COORD_WIDTH)) u_sep_ab (
      .clock (clock),
      .adv   (adv),
      .p     (a_pt),
      .q     (b_pt),
      .sep   (sep_ab)
   );

   // A is the reference, B's vertices are tested
   tpo_sep_unit #(.COORD_WIDTH(COORD_WIDTH)) u_sep_ba (
      .clock (clock),
      .adv   (adv),
      .p     (b_pt),
      .q     (a_pt),
      .sep   (sep_ba)
   );

   // separated if either direction finds a separating edge
   assign overlap_in = !(sep_ab || sep_ba);

   always_ff @(posedge clock) begin
      if (adv.load_out) begin
         overlap_ff <= overlap_in;
      end
   end

   assign rsp_chan.overlap = overlap_ff;

endmodule

FILE: rtl/tpo_checker.sv
module tpo_checker
   import tpo_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic overlap
);

   logic       req_fire;
   logic       rsp_fire;
   logic [3:0] inflight_ff;
   logic [3:0] inflight_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // transactions accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) inflight_in = inflight_ff + 4'd1;
      if (!req_fire && rsp_fire) inflight_in = inflight_ff - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(overlap))
      else $error("rsp payload changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 4'd0)
      else $error("response without an outstanding request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 4'(PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

endmodule

bind triangle_pair_overlap_test tpo_checker u_tpo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .overlap   (rsp_chan.overlap)
);

FILE: sim/triangle_pair_overlap_test_tb.sv
`timescale 1ns / 1ps

module triangle_pair_overlap_test_tb
   import tpo_pkg::*;
;

   localparam int COORD_W        = 16;
   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 300;          // long response stall for the fill test
   localparam int DRAIN_LIMIT    = 5000;         // cycles to wait for outstanding results
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_PRINTED    = 50;           // keep the log short on a broken build

   typedef logic signed [COORD_W-1:0] coord_type;

   // one triangle, vertex order as on the request channel
   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
   } tri_type;

   typedef struct packed {
      tri_type a;
      tri_type b;
   } pair_type;

   // predicted response, tagged with the request sequence number
   typedef struct packed {
      logic [31:0] seq;
      logic        overlap;
   } overlap_entry_type;

   logic clock = 1'b0;
   logic reset;

   tpo_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   tpo_rsp_if                          rsp_chan ();

   triangle_pair_overlap_test #(
      .COORD_WIDTH(COORD_W)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   overlap_entry_type overlap_expected_q[$];
   int                error_count   = 0;
   int                sent_count    = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   logic              rsp_hold;
   event              hold_start;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endtask

   // ------------------------------------------------------------------
   // Overlap predictor
   // ------------------------------------------------------------------
   // True when all three vertices of 'tested' sit on the far side of (or on)
   // one edge of 'ref_tri'. Exact 64-bit arithmetic: for 16-bit coordinates
   // every term fits in well under 40 bits, so nothing wraps.
   function automatic bit all_beyond_edge(input tri_type tested, input tri_type ref_tri);
      longint px[3];
      longint py[3];
      longint qx[3];
      longint qy[3];
      longint dx21, dy12, dy20, dx02, area, dx, dy, s, t, e;
      bit     area_neg;
      bit     s_all, t_all, st_all;
      int     i;
      px[0] = $signed(tested.x0);   py[0] = $signed(tested.y0);
      px[1] = $signed(tested.x1);   py[1] = $signed(tested.y1);
      px[2] = $signed(tested.x2);   py[2] = $signed(tested.y2);
      qx[0] = $signed(ref_tri.x0);  qy[0] = $signed(ref_tri.y0);
      qx[1] = $signed(ref_tri.x1);  qy[1] = $signed(ref_tri.y1);
      qx[2] = $signed(ref_tri.x2);  qy[2] = $signed(ref_tri.y2);
      dx21 = qx[2] - qx[1];
      dy12 = qy[1] - qy[2];
      dy20 = qy[2] - qy[0];
      dx02 = qx[0] - qx[2];
      area = dy12 * dx02 + dx21 * (qy[0] - qy[2]);
      // collinear reference gives area 0 and falls in the non-negative sense
      area_neg = (area < 0);
      s_all  = 1'b1;
      t_all  = 1'b1;
      st_all = 1'b1;
      for (i = 0; i < 3; i++) begin
         dx = px[i] - qx[2];
         dy = py[i] - qy[2];
         s  = dy12 * dx + dx21 * dy;
         t  = dy20 * dx + dx02 * dy;
         e  = s + t - area;
         // a vertex exactly on the edge counts as beyond it
         if (area_neg) begin
            if (s < 0) s_all  = 1'b0;
            if (t < 0) t_all  = 1'b0;
            if (e > 0) st_all = 1'b0;
         end else begin
            if (s > 0) s_all  = 1'b0;
            if (t > 0) t_all  = 1'b0;
            if (e < 0) st_all = 1'b0;
         end
      end
      return s_all || t_all || st_all;
   endfunction

   // separated if either triangle has an edge with the other wholly beyond it
   function automatic logic predict_overlap(input tri_type a, input tri_type b);
      return !(all_beyond_edge(a, b) || all_beyond_edge(b, a));
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic coord_type clamp_coord(input int v);
      if (v > 32767) return coord_type'(32767);
      if (v < -32768) return coord_type'(-32768);
      return coord_type'(v);
   endfunction

   function automatic coord_type near_coord(input int center, input int radius);
      return clamp_coord(center + int'($urandom_range(2 * radius)) - radius);
   endfunction

   function automatic tri_type make_tri(input int x0, input int y0, input int x1,
                                        input int y1, input int x2, input int y2);
      tri_type tr;
      tr.x0 = coord_type'(x0);  tr.y0 = coord_type'(y0);
      tr.x1 = coord_type'(x1);  tr.y1 = coord_type'(y1);
      tr.x2 = coord_type'(x2);  tr.y2 = coord_type'(y2);
      return tr;
   endfunction

   function automatic tri_type tri_near(input int cx, input int cy, input int radius);
      tri_type tr;
      tr.x0 = near_coord(cx, radius);  tr.y0 = near_coord(cy, radius);
      tr.x1 = near_coord(cx, radius);  tr.y1 = near_coord(cy, radius);
      tr.x2 = near_coord(cx, radius);  tr.y2 = near_coord(cy, radius);
      return tr;
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(6))
         0:       return coord_type'(-32768);
         1:       return coord_type'(-32767);
         2:       return coord_type'(-1);
         3:       return coord_type'(0);
         4:       return coord_type'(1);
         5:       return coord_type'(32766);
         default: return coord_type'(32767);
      endcase
   endfunction

   // three points on one line through (bx, by)
   function automatic tri_type collinear_tri(input int bx, input int by);
      int dx, dy, k1, k2;
      dx = int'($urandom_range(100)) - 50;
      dy = int'($urandom_range(100)) - 50;
      k1 = int'($urandom_range(40)) - 20;
      k2 = int'($urandom_range(40)) - 20;
      return make_tri(bx, by, bx + k1 * dx, by + k1 * dy, bx + k2 * dx, by + k2 * dy);
   endfunction

   function automatic int radius_pick();
      case ($urandom_range(3))
         0:       return 4;
         1:       return 64;
         2:       return 1024;
         default: return 16384;
      endcase
   endfunction

   // mix: wide random, local clusters (both outcomes), shared edges and
   // vertices (touching), collinear triangles, and extreme coordinates
   function automatic pair_type random_triangle_pair();
      pair_type p;
      int       mode, cx, cy, r;
      mode = $urandom_range(99);
      cx   = int'($urandom_range(60000)) - 30000;
      cy   = int'($urandom_range(60000)) - 30000;
      r    = radius_pick();
      if (mode < 25) begin
         p = pair_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end else if (mode < 60) begin
         p.a = tri_near(cx, cy, r);
         p.b = tri_near(cx, cy, r);
      end else if (mode < 80) begin
         p.a = tri_near(cx, cy, r);
         p.b = tri_near(cx, cy, r);
         p.b.x0 = p.a.x1;
         p.b.y0 = p.a.y1;
         if ($urandom_range(1)) begin
            p.b.x1 = p.a.x2;
            p.b.y1 = p.a.y2;
         end
      end else if (mode < 90) begin
         p.a = $urandom_range(1) ? collinear_tri(cx / 40, cy / 40)
                                 : tri_near(cx / 40, cy / 40, 1024);
         p.b = collinear_tri(cx / 40, cy / 40);
      end else begin
         p.a.x0 = extreme_coord();  p.a.y0 = extreme_coord();
         p.a.x1 = extreme_coord();  p.a.y1 = extreme_coord();
         p.a.x2 = extreme_coord();  p.a.y2 = extreme_coord();
         p.b.x0 = extreme_coord();  p.b.y0 = extreme_coord();
         p.b.x1 = extreme_coord();  p.b.y1 = extreme_coord();
         p.b.x2 = extreme_coord();  p.b.y2 = extreme_coord();
      end
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: random idle gaps, then hold the transaction until
   // accepted. valid stays high across back-to-back transactions.
   // ------------------------------------------------------------------
   task automatic send_pair(input tri_type a, input tri_type b);
      overlap_entry_type entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.a_x0  <= a.x0;
      req_chan.a_y0  <= a.y0;
      req_chan.a_x1  <= a.x1;
      req_chan.a_y1  <= a.y1;
      req_chan.a_x2  <= a.x2;
      req_chan.a_y2  <= a.y2;
      req_chan.b_x0  <= b.x0;
      req_chan.b_y0  <= b.y0;
      req_chan.b_x1  <= b.x1;
      req_chan.b_y1  <= b.y1;
      req_chan.b_x2  <= b.x2;
      req_chan.b_y2  <= b.y2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      entry.seq     = sent_count;
      entry.overlap = predict_overlap(a, b);
      overlap_expected_q.insert(overlap_expected_q.size(), entry);
      sent_count++;
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure, plus a long hold on request
   // ------------------------------------------------------------------
   initial begin
      rsp_hold <= 1'b0;
      forever begin
         @(hold_start);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker: every accepted response is matched in order
   always @(posedge clock) begin
      overlap_entry_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (overlap_expected_q.size() == 0) begin
            report_mismatch($sformatf("response with no pending transaction, overlap=%0b",
                                      rsp_chan.overlap));
         end else begin
            want = overlap_expected_q.pop_front();
            if (rsp_chan.overlap !== want.overlap) begin
               report_mismatch($sformatf("transaction %0d: overlap=%0b, predicted %0b",
                                         want.seq, rsp_chan.overlap, want.overlap));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_cases();
      // extremes: every coordinate at the minimum, then at the maximum
      send_pair(make_tri(-32768, -32768, -32768, -32768, -32768, -32768),
                make_tri(-32768, -32768, -32768, -32768, -32768, -32768));
      send_pair(make_tri(32767, 32767, 32767, 32767, 32767, 32767),
                make_tri(32767, 32767, 32767, 32767, 32767, 32767));
      // full-span triangles, then small ones at opposite corners of the coordinate range
      send_pair(make_tri(-32768, -32768, 32767, -32768, -32768, 32767),
                make_tri(32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(make_tri(-32768, 32767, 32767, -32768, -32768, -32768),
                make_tri(32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(make_tri(-32768, -32768, -32767, -32768, -32768, -32767),
                make_tri(32767, 32767, 32766, 32767, 32767, 32766));
      // identical triangles, counter-clockwise, clockwise, and mixed winding
      send_pair(make_tri(0, 0, 100, 0, 0, 100), make_tri(0, 0, 100, 0, 0, 100));
      send_pair(make_tri(0, 0, 0, 100, 100, 0), make_tri(0, 0, 0, 100, 100, 0));
      send_pair(make_tri(0, 0, 100, 0, 0, 100), make_tri(0, 0, 0, 100, 100, 0));
      // touching along a shared edge, then at a single vertex: separated
      send_pair(make_tri(0, 0, 100, 0, 0, 100), make_tri(100, 0, 0, 100, 100, 100));
      send_pair(make_tri(0, 0, 10, 0, 0, 10), make_tri(10, 0, 20, 0, 10, 10));
      // vertex on the hypotenuse vs one unit across it
      send_pair(make_tri(0, 0, 100, 0, 0, 100), make_tri(50, 50, 100, 100, 100, 50));
      send_pair(make_tri(0, 0, 100, 0, 0, 100), make_tri(49, 50, 100, 100, 100, 50));
      // clockwise reference with a vertex on its edge
      send_pair(make_tri(0, 0, 0, 100, 100, 0), make_tri(50, 50, 100, 50, 100, 100));
      // containment, crossing star, far apart
      send_pair(make_tri(-1000, -1000, 1000, -1000, 0, 1000), make_tri(-5, 0, 5, 0, 0, 5));
      send_pair(make_tri(0, 0, 60, 0, 30, 52), make_tri(0, 35, 60, 35, 30, -17));
      send_pair(make_tri(-30000, -30000, -29000, -30000, -30000, -29000),
                make_tri(30000, 30000, 29000, 30000, 30000, 29000));
      // collinear reference on either side, then both collinear: crossing, then parallel
      send_pair(make_tri(0, 0, 50, 50, 100, 100), make_tri(0, 100, 100, 0, 100, 100));
      send_pair(make_tri(0, 100, 100, 0, 100, 100), make_tri(0, 0, 50, 50, 100, 100));
      send_pair(make_tri(0, 0, 50, 50, 100, 100), make_tri(0, 100, 50, 50, 100, 0));
      send_pair(make_tri(0, 0, 50, 50, 100, 100), make_tri(0, 10, 50, 60, 100, 110));
      // alternating bit patterns in every field
      send_pair(make_tri(21845, -21846, -21846, 21845, 21845, 21845),
                make_tri(-21846, -21846, 21845, -21846, -21846, 21845));
   endtask

   task automatic test_random_pairs(input int count, input int send_pct, input int recv_pct);
      pair_type p;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         p = random_triangle_pair();
         send_pair(p.a, p.b);
      end
   endtask

   // Response side stalls for a long stretch while requests keep coming,
   // so the pipeline fills and request ready must drop without loss.
   task automatic test_output_backpressure(input int count);
      pair_type p;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      -> hold_start;
      repeat (count) begin
         p = random_triangle_pair();
         send_pair(p.a, p.b);
      end
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while (overlap_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // extra cycles to catch any stray response
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      if (overlap_expected_q.size() != 0) begin
         report_mismatch($sformatf("%0d transactions never answered",
                                   overlap_expected_q.size()));
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.a_x0  <= '0;
      req_chan.a_y0  <= '0;
      req_chan.a_x1  <= '0;
      req_chan.a_y1  <= '0;
      req_chan.a_x2  <= '0;
      req_chan.a_y2  <= '0;
      req_chan.b_x0  <= '0;
      req_chan.b_y0  <= '0;
      req_chan.b_x1  <= '0;
      req_chan.b_y1  <= '0;
      req_chan.b_x2  <= '0;
      req_chan.b_y2  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 60;
      test_directed_cases();
      test_random_pairs(330, 15, 60);
      test_random_pairs(330, 60, 15);
      test_random_pairs(330, 0, 0);
      test_output_backpressure(60);

      req_chan.valid <= 1'b0;
      recv_idle_pct = 0;
      wait_for_drain();

      if (error_count == 0) begin
         $display("triangle_pair_overlap_test regression: pass");
      end else begin
         $display("triangle_pair_overlap_test regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("TIMEOUT after %0d cycles", TIMEOUT_CYCLES);
      $display("triangle_pair_overlap_test regression: fail");
      $finish;
   end

endmodule
